/* rtl/core/bcaf_pkg.sv */
// Shared types and codes for the three-button chord and auto-repeat front end.
`default_nettype none
package bcaf_pkg;

   // Word layouts
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 8;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned THRESH_W   = 16;

   // Item kind carried in req_tuser
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // Pin sources
   localparam logic [1:0] PIN_PLUS  = 2'd0;
   localparam logic [1:0] PIN_MINUS = 2'd1;
   localparam logic [1:0] PIN_SS    = 2'd2;
   localparam logic [1:0] PIN_OTHER = 2'd3;

   // Timer modes seen at the input
   localparam logic [1:0] TMODE_SETUP     = 2'd0;
   localparam logic [1:0] TMODE_STOPPED   = 2'd1;
   localparam logic [1:0] TMODE_COUNTDOWN = 2'd2;
   localparam logic [1:0] TMODE_OTHER     = 2'd3;

   // Requested modes on the result side
   localparam logic [1:0] NMODE_COUNTDOWN  = 2'd0;
   localparam logic [1:0] NMODE_STOPPED    = 2'd1;
   localparam logic [1:0] NMODE_RESET      = 2'd2;
   localparam logic [1:0] NMODE_ALARM_STOP = 2'd3;

   // Held-button flags
   localparam logic [1:0] HELD_PLUS  = 2'b01;
   localparam logic [1:0] HELD_MINUS = 2'b10;

   // Long-press threshold after reset
   localparam logic [THRESH_W-1:0] LONG_PRESS_RESET = 16'd500;

   // Chord stamp and release stamp
   localparam logic [TICK_W-1:0] STAMP_CHORD   = 32'h0000_0001;
   localparam logic [TICK_W-1:0] STAMP_RELEASE = 32'h0000_0000;

   // Pending event, one-hot
   typedef enum logic [7:0] {
      EV_NONE    = 8'b0000_0001,
      EV_P_DOWN  = 8'b0000_0010,
      EV_P_UP    = 8'b0000_0100,
      EV_M_DOWN  = 8'b0000_1000,
      EV_M_UP    = 8'b0001_0000,
      EV_CHORD   = 8'b0010_0000,
      EV_SS_DOWN = 8'b0100_0000,
      EV_SS_UP   = 8'b1000_0000
   } event_type;

   // Result word
   typedef struct packed {
      logic       idle_clear;
      logic       display_update;
      logic       store_minutes;
      logic [1:0] new_mode;
      logic       mode_change_valid;
      logic       decrease_pulse;
      logic       increase_pulse;
   } rsp_word_type;

endpackage
`default_nettype wire

/* rtl/core/button_chord_autorepeat_fsm.sv */
// Top level: button event latch, hold timing and mode requests for a countdown timer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  req     | in        | req_tvalid/req_tready| req_tuser operation, req_tdata fields
//  rsp     | out       | rsp_tvalid/rsp_tready| rsp_tdata result flags and new mode
//  csr     | in        | csr_wen              | csr_wdata long-press threshold
//
// One word per cycle unless the receiver stalls: each accepted word is worked in the
// cycle it arrives and its result sits in the output register the next cycle.
// The path is one 32-bit subtract and a compare against the threshold.
// A new word is taken whenever the output register is empty or being drained.
// Reset clears the pending event, held flags, press stamp and the output valid,
// and loads the threshold with 500.
`default_nettype none
module button_chord_autorepeat_fsm (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [1:0] pin_select, [2] pin_level, [34:3] tick_now, [36:35] timer_mode,
   // [37] alarm_active, [39:38] zero
   input  wire logic [bcaf_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] operation
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] increase_pulse, [1] decrease_pulse, [2] mode_change_valid,
   // [4:3] new_mode, [5] store_minutes, [6] display_update, [7] idle_clear
   output logic [bcaf_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_wen,
   input  wire logic [bcaf_pkg::THRESH_W-1:0]     csr_wdata
);
   import bcaf_pkg::*;

   // Unpacked input word
   logic              op;
   logic [1:0]        pin_select;
   logic              pin_level;
   logic [TICK_W-1:0] tick_now;
   logic [1:0]        timer_mode;
   logic              alarm_active;

   // State and next state
   event_type           pending_ff, pending_in;
   logic [1:0]          held_ff, held_in;
   logic [TICK_W-1:0]   stamp_ff, stamp_in;
   logic [THRESH_W-1:0] long_press_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_word_ff, rsp_word_in;

   logic                req_fire;
   logic [TICK_W-1:0]   held_time;
   logic                long_held;
   logic [1:0]          own_flag;
   logic [1:0]          other_flag;
   logic                own_pulse;

   assign op           = req_tuser;
   assign pin_select   = req_tdata[1:0];
   assign pin_level    = req_tdata[2];
   assign tick_now     = req_tdata[34:3];
   assign timer_mode   = req_tdata[36:35];
   assign alarm_active = req_tdata[37];

   // Output register frees when empty or drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

   // Held time, wraps modulo 2^32
   assign held_time = tick_now - stamp_ff;
   assign long_held = held_time > {{(TICK_W-THRESH_W){1'b0}}, long_press_ff};

   // Which button a pending push refers to
   assign own_flag   = (pending_ff == EV_M_DOWN) ? HELD_MINUS : HELD_PLUS;
   assign other_flag = (pending_ff == EV_M_DOWN) ? HELD_PLUS  : HELD_MINUS;

   // Per-word event handling
   always_comb begin
      pending_in  = pending_ff;
      held_in     = held_ff;
      stamp_in    = stamp_ff;
      rsp_word_in = '0;
      own_pulse   = 1'b0;
      if (op == OP_EDGE) begin
         rsp_word_in.idle_clear = 1'b1;
         unique case (pin_select)
            PIN_PLUS:  pending_in = pin_level ? EV_P_DOWN  : EV_P_UP;
            PIN_MINUS: pending_in = pin_level ? EV_M_DOWN  : EV_M_UP;
            PIN_SS:    pending_in = pin_level ? EV_SS_DOWN : EV_SS_UP;
            PIN_OTHER: pending_in = pending_ff;
            default:   pending_in = pending_ff;
         endcase
      end else begin
         unique case (pending_ff)
            EV_P_DOWN, EV_M_DOWN: begin
               // push: chord, first press or auto-repeat
               if ((held_ff & other_flag) != 2'b00) begin
                  pending_in = EV_CHORD;
                  stamp_in   = STAMP_CHORD;
               end else if ((held_ff & own_flag) == 2'b00) begin
                  stamp_in  = tick_now;
                  held_in   = held_ff | own_flag;
                  own_pulse = 1'b1;
               end else if (long_held) begin
                  stamp_in  = tick_now;
                  own_pulse = 1'b1;
               end
            end
            EV_P_UP: begin
               held_in    = held_ff & ~HELD_PLUS;
               stamp_in   = STAMP_RELEASE;
               pending_in = EV_NONE;
            end
            EV_M_UP: begin
               held_in    = held_ff & ~HELD_MINUS;
               stamp_in   = STAMP_RELEASE;
               pending_in = EV_NONE;
            end
            EV_CHORD: begin
               rsp_word_in.mode_change_valid = 1'b1;
               rsp_word_in.new_mode          = NMODE_RESET;
               pending_in                    = EV_NONE;
            end
            EV_SS_DOWN: begin
               priority if (timer_mode == TMODE_SETUP || timer_mode == TMODE_STOPPED) begin
                  rsp_word_in.mode_change_valid = 1'b1;
                  rsp_word_in.new_mode          = NMODE_COUNTDOWN;
                  rsp_word_in.store_minutes     = 1'b1;
               end else if (timer_mode == TMODE_COUNTDOWN) begin
                  rsp_word_in.mode_change_valid = 1'b1;
                  rsp_word_in.new_mode          = NMODE_STOPPED;
               end else if (alarm_active) begin
                  rsp_word_in.mode_change_valid = 1'b1;
                  rsp_word_in.new_mode          = NMODE_ALARM_STOP;
               end
               rsp_word_in.display_update = 1'b1;
               pending_in                 = EV_NONE;
            end
            EV_NONE, EV_SS_UP: begin
               pending_in = pending_ff;
            end
            default: begin
               pending_in = pending_ff;
            end
         endcase
         rsp_word_in.increase_pulse = own_pulse && (pending_ff == EV_P_DOWN);
         rsp_word_in.decrease_pulse = own_pulse && (pending_ff == EV_M_DOWN);
      end
   end

   // Output valid follows accepts and drains
   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= EV_NONE;
         held_ff       <= 2'b00;
         stamp_ff      <= '0;
         long_press_ff <= LONG_PRESS_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            pending_ff <= pending_in;
            held_ff    <= held_in;
            stamp_ff   <= stamp_in;
         end
         if (csr_wen) begin
            long_press_ff <= csr_wdata;
         end
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/bcaf_port_checker.sv */
// Port-level checks for the button front end, bound to the top level.
`default_nettype none
module bcaf_port_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [bcaf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import bcaf_pkg::*;

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // An edge word yields only idle_clear on the next cycle
   a_edge_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_EDGE
      |=> rsp_tvalid && rsp_tdata == 8'h80)
      else $error("edge word gave more than idle_clear");

   // A poll word never clears the idle timer
   a_poll_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == OP_POLL
      |=> rsp_tvalid && !rsp_tdata[7])
      else $error("poll word set idle_clear");

   // Only one step direction at a time; new mode is zero without a request
   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1])
                     && (rsp_tdata[2] || rsp_tdata[4:3] == 2'd0))
      else $error("malformed result word");

endmodule

bind button_chord_autorepeat_fsm bcaf_port_checker u_bcaf_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

/* bench/tb_button_chord_autorepeat_fsm.sv */
// Self-checking bench for the button chord and auto-repeat front end.
`timescale 1ns / 1ps
module tb_button_chord_autorepeat_fsm;
   import bcaf_pkg::*;

   localparam int WATCHDOG_CYCLES = 4000;
   localparam int MAX_REPORTS     = 10;

   // Clock and reset
   logic clock;
   logic reset = 1'b1;

   // Block ports; every input is known from time zero
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [1:0] pin_select, [2] pin_level, [34:3] tick_now, [36:35] timer_mode,
   // [37] alarm_active, [39:38] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // [0] operation
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [0] increase_pulse, [1] decrease_pulse, [2] mode_change_valid,
   // [4:3] new_mode, [5] store_minutes, [6] display_update, [7] idle_clear
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen    = 1'b0;
   logic [THRESH_W-1:0]   csr_wdata  = '0;

   button_chord_autorepeat_fsm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Shadow copy of the block state and threshold
   event_type           m_pending = EV_NONE;
   logic [1:0]          m_held    = 2'b00;
   logic [TICK_W-1:0]   m_stamp   = '0;
   logic [THRESH_W-1:0] m_thresh  = LONG_PRESS_RESET;

   rsp_word_type predicted_rsp_q[$];
   logic [TICK_W-1:0] tick_cursor = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int errors        = 0;
   int items_sent    = 0;
   int rsp_checked   = 0;
   int pulses_seen   = 0;
   int mode_reqs     = 0;
   int resets_seen   = 0;
   int stores_seen   = 0;
   int idle_cycles   = 0;

   // Plus or minus push seen at a poll: chord, first pulse or repeat
   function automatic logic hold_step(input logic [1:0] own, input logic [1:0] other,
                                      input logic [TICK_W-1:0] tick);
      logic              pulse;
      logic [TICK_W-1:0] held_for;
      pulse    = 1'b0;
      held_for = tick - m_stamp;
      if ((m_held & other) != 2'b00) begin
         m_pending = EV_CHORD;
         m_stamp   = STAMP_CHORD;
      end else if ((m_held & own) == 2'b00) begin
         m_stamp = tick;
         m_held  = m_held | own;
         pulse   = 1'b1;
      end else if (held_for > {16'd0, m_thresh}) begin
         m_stamp = tick;
         pulse   = 1'b1;
      end
      return pulse;
   endfunction

   function automatic void release_step(input logic [1:0] own);
      m_held    = m_held & ~own;
      m_stamp   = STAMP_RELEASE;
      m_pending = EV_NONE;
   endfunction

   // Result word for one accepted word; advances the shadow state
   function automatic rsp_word_type predict_rsp(input logic op, input logic [1:0] pin,
                                                input logic level,
                                                input logic [TICK_W-1:0] tick,
                                                input logic [1:0] mode, input logic alarm);
      rsp_word_type r;
      r = '0;
      if (op == OP_EDGE) begin
         r.idle_clear = 1'b1;
         case (pin)
            PIN_PLUS:  if (level) m_pending = EV_P_DOWN;  else m_pending = EV_P_UP;
            PIN_MINUS: if (level) m_pending = EV_M_DOWN;  else m_pending = EV_M_UP;
            PIN_SS:    if (level) m_pending = EV_SS_DOWN; else m_pending = EV_SS_UP;
            default: ;
         endcase
      end else begin
         case (m_pending)
            EV_P_DOWN: r.increase_pulse = hold_step(HELD_PLUS, HELD_MINUS, tick);
            EV_P_UP:   release_step(HELD_PLUS);
            EV_M_DOWN: r.decrease_pulse = hold_step(HELD_MINUS, HELD_PLUS, tick);
            EV_M_UP:   release_step(HELD_MINUS);
            EV_CHORD: begin
               r.mode_change_valid = 1'b1;
               r.new_mode          = NMODE_RESET;
               m_pending           = EV_NONE;
            end
            EV_SS_DOWN: begin
               if (mode == TMODE_SETUP || mode == TMODE_STOPPED) begin
                  r.mode_change_valid = 1'b1;
                  r.new_mode          = NMODE_COUNTDOWN;
                  r.store_minutes     = 1'b1;
               end else if (mode == TMODE_COUNTDOWN) begin
                  r.mode_change_valid = 1'b1;
                  r.new_mode          = NMODE_STOPPED;
               end else if (alarm) begin
                  r.mode_change_valid = 1'b1;
                  r.new_mode          = NMODE_ALARM_STOP;
               end
               r.display_update = 1'b1;
               m_pending        = EV_NONE;
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic string word_text(input rsp_word_type w);
      return $sformatf("inc=%0b dec=%0b mv=%0b mode=%0d store=%0b disp=%0b idle=%0b",
                       w.increase_pulse, w.decrease_pulse, w.mode_change_valid,
                       w.new_mode, w.store_minutes, w.display_update, w.idle_clear);
   endfunction

   // Send one word after a random gap; predict it at the accepting edge
   task automatic send_word(input logic op, input logic [1:0] pin, input logic level,
                            input logic [TICK_W-1:0] tick, input logic [1:0] mode,
                            input logic alarm);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, alarm, mode, tick, level, pin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted_rsp_q.push_back(predict_rsp(op, pin, level, tick, mode, alarm));
      items_sent++;
   endtask

   // Pin edge with random filler in the unused fields
   task automatic pin_change(input logic [1:0] pin, input logic level);
      send_word(OP_EDGE, pin, level, $urandom, 2'($urandom_range(3)),
                1'($urandom_range(1)));
   endtask

   task automatic poll_word(input logic [TICK_W-1:0] tick, input logic [1:0] mode,
                            input logic alarm);
      send_word(OP_POLL, 2'($urandom_range(3)), 1'($urandom_range(1)), tick, mode, alarm);
   endtask

   // Drop valid and wait for every result to come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Threshold write, only with the block idle
   task automatic set_long_press(input logic [THRESH_W-1:0] value);
      drain_results();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      m_thresh   = value;
   endtask

   // Next poll tick: mostly a step around the threshold, now and then anywhere
   function automatic logic [TICK_W-1:0] next_tick();
      if ($urandom_range(9) == 0)
         tick_cursor = $urandom;
      else
         tick_cursor = tick_cursor + $urandom_range(0, 2 * int'(m_thresh) + 2);
      return tick_cursor;
   endfunction

   // Hand-picked cases at the reset threshold of 500
   task automatic test_directed_cases();
      poll_word(32'd0, TMODE_SETUP, 1'b0);
      send_word(OP_EDGE, PIN_PLUS, 1'b1, 32'hFFFF_FFFF, TMODE_OTHER, 1'b1);
      poll_word(32'd100, TMODE_SETUP, 1'b0);         // first push pulse
      poll_word(32'd600, TMODE_SETUP, 1'b0);         // held exactly 500: no repeat
      poll_word(32'd601, TMODE_SETUP, 1'b0);         // just past: repeat
      pin_change(PIN_MINUS, 1'b1);                   // chord while plus held
      poll_word(32'd700, TMODE_SETUP, 1'b0);
      poll_word(32'd701, TMODE_SETUP, 1'b0);         // reset request
      pin_change(PIN_PLUS, 1'b0);
      poll_word(32'd800, TMODE_SETUP, 1'b0);
      pin_change(PIN_MINUS, 1'b1);                   // fresh minus push, nothing held
      poll_word(32'd0, TMODE_SETUP, 1'b0);
      poll_word(32'hFFFF_FFFF, TMODE_SETUP, 1'b0);
      poll_word(32'd501, TMODE_SETUP, 1'b0);         // held time wraps round
      pin_change(PIN_MINUS, 1'b0);
      poll_word(32'd900, TMODE_SETUP, 1'b0);
      // start/stop in each timer mode, with a foreign pin edge in between once
      pin_change(PIN_SS, 1'b1);
      poll_word($urandom, TMODE_SETUP, 1'b0);
      pin_change(PIN_SS, 1'b1);
      poll_word($urandom, TMODE_STOPPED, 1'b1);
      pin_change(PIN_SS, 1'b1);
      poll_word($urandom, TMODE_COUNTDOWN, 1'b0);
      pin_change(PIN_SS, 1'b1);
      poll_word($urandom, TMODE_OTHER, 1'b0);        // no request, display only
      pin_change(PIN_SS, 1'b1);
      send_word(OP_EDGE, PIN_OTHER, 1'b1, 32'd0, TMODE_SETUP, 1'b0);
      poll_word($urandom, TMODE_OTHER, 1'b1);        // alarm stop
      pin_change(PIN_SS, 1'b0);
      poll_word($urandom, TMODE_SETUP, 1'b0);        // release stays pending, no effect
   endtask

   // Repeat boundary at both ends of the threshold range
   task automatic test_threshold_extremes();
      set_long_press(16'd0);
      pin_change(PIN_PLUS, 1'b1);
      poll_word(32'd1000, TMODE_SETUP, 1'b0);
      poll_word(32'd1000, TMODE_SETUP, 1'b0);
      poll_word(32'd1001, TMODE_SETUP, 1'b0);
      pin_change(PIN_PLUS, 1'b0);
      poll_word(32'd1002, TMODE_SETUP, 1'b0);
      set_long_press(16'hFFFF);
      pin_change(PIN_MINUS, 1'b1);
      poll_word(32'd0, TMODE_COUNTDOWN, 1'b0);
      poll_word(32'd65535, TMODE_COUNTDOWN, 1'b0);
      poll_word(32'd65536, TMODE_COUNTDOWN, 1'b0);
      pin_change(PIN_MINUS, 1'b0);
      poll_word(32'd70000, TMODE_COUNTDOWN, 1'b0);
   endtask

   // Press/release sequences with polls, plus some raw noise
   task automatic random_phase(input int n_items, input int idle_pct, input int stall_pct,
                               input logic [THRESH_W-1:0] thresh);
      int         sent;
      int         n_polls;
      int         pick;
      logic [1:0] pin;
      set_long_press(thresh);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(9);
            if (pick < 4)      pin = PIN_PLUS;
            else if (pick < 8) pin = PIN_MINUS;
            else if (pick < 9) pin = PIN_SS;
            else               pin = PIN_OTHER;
            pin_change(pin, 1'($urandom_range(99) < 60));
            n_polls = $urandom_range(1, 4);
            for (int i = 0; i < n_polls; i++)
               poll_word(next_tick(), 2'($urandom_range(3)), 1'($urandom_range(1)));
            sent += 1 + n_polls;
         end else begin
            send_word(1'($urandom_range(1)), 2'($urandom_range(3)), 1'($urandom_range(1)),
                      $urandom, 2'($urandom_range(3)), 1'($urandom_range(1)));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      random_phase(225, 0, 0, 16'hFFFF);
      random_phase(225, 60, 0, 16'd0);
      random_phase(225, 0, 60, 16'($urandom_range(1, 2000)));
      random_phase(225, 38, 38, LONG_PRESS_RESET);
   endtask

   // Receiver stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   // Result checker
   always @(posedge clock) begin : check_rsp
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         rsp_checked++;
         if (predicted_rsp_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("ERROR: unexpected result word: %s", word_text(got));
         end else begin
            want = predicted_rsp_q.pop_front();
            if (got.increase_pulse    !== want.increase_pulse    ||
                got.decrease_pulse    !== want.decrease_pulse    ||
                got.mode_change_valid !== want.mode_change_valid ||
                got.new_mode          !== want.new_mode          ||
                got.store_minutes     !== want.store_minutes     ||
                got.display_update    !== want.display_update    ||
                got.idle_clear        !== want.idle_clear) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("ERROR: result %0d expected %s got %s", rsp_checked,
                           word_text(want), word_text(got));
            end
         end
         pulses_seen += got.increase_pulse + got.decrease_pulse;
         if (got.mode_change_valid) begin
            mode_reqs++;
            if (got.new_mode == NMODE_RESET) resets_seen++;
         end
         stores_seen += got.store_minutes;
      end
   end

   // Watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("ERROR: no handshake for %0d cycles", WATCHDOG_CYCLES);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_threshold_extremes();
      test_random_traffic();
      drain_results();
      repeat (4) @(posedge clock);
      errors += predicted_rsp_q.size();
      $display("Covered %0d words in, %0d results out, across idle/stall mixes",
               items_sent, rsp_checked);
      $display({"and thresholds 0, 65535, 500 and random: %0d pulses, ",
                "%0d mode requests (%0d resets, %0d stores)"},
               pulses_seen, mode_reqs, resets_seen, stores_seen);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
